// File: design/v4n_pkg.sv
`timescale 1ns / 1ps
package v4n_pkg;

  // Pipeline depths.
  localparam int unsigned FRONT_STAGES = 4;   // magnitude, square, pair sum, total
  localparam int unsigned SQRT_STAGES  = 33;  // one root bit per stage
  localparam int unsigned DIV_STAGES   = 31;  // one quotient bit per stage
  localparam int unsigned MAG_DELAY    = FRONT_STAGES + SQRT_STAGES;
  localparam int unsigned VALID_DEPTH  = FRONT_STAGES + SQRT_STAGES + DIV_STAGES;
  localparam int unsigned LATENCY      = VALID_DEPTH + 1;

  // Unity in signed Q2.30.
  localparam logic [30:0] ONE_Q230 = 31'h4000_0000;

  typedef struct packed {
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic signed [31:0] comp_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
    logic signed [31:0] unit_w;
    logic [32:0]        length;
    logic               was_zero;
  } out_t;

endpackage

// File: design/v4n_sqrt.sv
`timescale 1ns / 1ps
module v4n_sqrt import v4n_pkg::*; (
  input  logic        clk_i,
  input  logic [65:0] rad_i,
  output logic [32:0] root_o
);

  logic [34:0] rem_in  [SQRT_STAGES];
  logic [32:0] root_in [SQRT_STAGES];
  logic [65:0] rad_in  [SQRT_STAGES];
  logic [34:0] rem_q   [SQRT_STAGES];
  logic [32:0] root_q  [SQRT_STAGES];
  logic [65:0] rad_q   [SQRT_STAGES];

  // Digit-by-digit square root: each stage brings in two radicand bits.
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [36:0] cur;
    logic [36:0] trial;

    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign rad_in[k]  = rad_i;
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign root_in[k] = root_q[k-1];
      assign rad_in[k]  = rad_q[k-1];
    end

    assign cur   = {rem_in[k], rad_in[k][65:64]};
    assign trial = {2'b00, root_in[k][32:0], 2'b01};

    always_ff @(posedge clk_i) begin
      rad_q[k] <= {rad_in[k][63:0], 2'b00};
      if (cur >= trial) begin
        rem_q[k]  <= 35'(cur - trial);
        root_q[k] <= {root_in[k][31:0], 1'b1};
      end else begin
        rem_q[k]  <= cur[34:0];
        root_q[k] <= {root_in[k][31:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// File: design/v4n_lane.sv
`timescale 1ns / 1ps
module v4n_lane import v4n_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] comp_i,
  output logic [63:0]        sq_o,
  input  logic [32:0]        len_i,
  output logic signed [31:0] unit_o
);

  logic [31:0] mag_q [MAG_DELAY];
  logic        neg_q [MAG_DELAY];
  logic [63:0] sq_q;

  // Magnitude and sign, held until the length arrives.
  always_ff @(posedge clk_i) begin
    neg_q[0] <= comp_i[31];
    mag_q[0] <= comp_i[31] ? 32'(-comp_i) : comp_i;
    for (int i = 1; i < MAG_DELAY; i++) begin
      neg_q[i] <= neg_q[i-1];
      mag_q[i] <= mag_q[i-1];
    end
  end

  // Square of the magnitude.
  always_ff @(posedge clk_i) begin
    sq_q <= 64'(mag_q[0]) * 64'(mag_q[0]);
  end

  assign sq_o = sq_q;

  // Restoring division of mag * 2^30 by the length, one quotient bit a stage.
  // The magnitude never exceeds the length, so the top 31 dividend bits are
  // already a valid partial remainder.
  logic [32:0] rem_in  [DIV_STAGES];
  logic [30:0] quo_in  [DIV_STAGES];
  logic [30:0] bits_in [DIV_STAGES];
  logic [32:0] div_in  [DIV_STAGES];
  logic        sgn_in  [DIV_STAGES];
  logic [32:0] rem_q   [DIV_STAGES];
  logic [30:0] quo_q   [DIV_STAGES];
  logic [30:0] bits_q  [DIV_STAGES];
  logic [32:0] div_q   [DIV_STAGES];
  logic        sgn_q   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [33:0] cur;

    if (k == 0) begin : g_first
      assign rem_in[k]  = {2'b00, mag_q[MAG_DELAY-1][31:1]};
      assign quo_in[k]  = '0;
      assign bits_in[k] = {mag_q[MAG_DELAY-1][0], 30'b0};
      assign div_in[k]  = len_i;
      assign sgn_in[k]  = neg_q[MAG_DELAY-1];
    end else begin : g_next
      assign rem_in[k]  = rem_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign bits_in[k] = bits_q[k-1];
      assign div_in[k]  = div_q[k-1];
      assign sgn_in[k]  = sgn_q[k-1];
    end

    assign cur = {rem_in[k], bits_in[k][30]};

    always_ff @(posedge clk_i) begin
      bits_q[k] <= {bits_in[k][29:0], 1'b0};
      div_q[k]  <= div_in[k];
      sgn_q[k]  <= sgn_in[k];
      if (cur >= {1'b0, div_in[k]}) begin
        rem_q[k] <= 33'(cur - {1'b0, div_in[k]});
        quo_q[k] <= {quo_in[k][29:0], 1'b1};
      end else begin
        rem_q[k] <= cur[32:0];
        quo_q[k] <= {quo_in[k][29:0], 1'b0};
      end
    end
  end

  // Clamp to unity and put the sign back.
  logic [31:0] quo_sat;
  always_comb begin
    quo_sat = (quo_q[DIV_STAGES-1] > ONE_Q230) ? {1'b0, ONE_Q230}
                                               : {1'b0, quo_q[DIV_STAGES-1]};
    unit_o  = sgn_q[DIV_STAGES-1] ? 32'(-quo_sat) : quo_sat;
  end

endmodule

// File: design/vec4_normalize.sv
`timescale 1ns / 1ps
// Normalises a four-component Q16.16 vector to Q2.30 unit length and reports
// its floored Q17.16 magnitude. The block is a fixed pipeline: it takes one
// transaction in every cycle (busy stays low) and shows the result on res_o
// with done_o high for one cycle. Each transaction passes through the
// 33-stage square root, one root bit per stage, followed by the 31-stage
// per-component dividers, one quotient bit per stage. Results cannot
// be held off, so the receiver must take each one in the cycle it appears.
module vec4_normalize import v4n_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output out_t res_o,
  output logic done_o
);

  logic [63:0]        sq [4];
  logic signed [31:0] unit [4];
  logic signed [31:0] comp [4];
  logic [32:0]        root;
  logic [64:0]        pair_q [2];
  logic [64:0]        total_q;
  logic [VALID_DEPTH-1:0] valid_q;
  logic               zero_q [VALID_DEPTH];
  logic [32:0]        len_q  [DIV_STAGES];
  out_t               res_q;
  logic               done_q;

  assign busy = 1'b0;

  assign comp[0] = in_i.comp_x;
  assign comp[1] = in_i.comp_y;
  assign comp[2] = in_i.comp_z;
  assign comp[3] = in_i.comp_w;

  // One lane per component.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    v4n_lane u_lane (
      .clk_i  (clk_i),
      .comp_i (comp[l]),
      .sq_o   (sq[l]),
      .len_i  (root),
      .unit_o (unit[l])
    );
  end

  // Squared magnitude as a registered adder tree.
  always_ff @(posedge clk_i) begin
    pair_q[0] <= {1'b0, sq[0]} + {1'b0, sq[1]};
    pair_q[1] <= {1'b0, sq[2]} + {1'b0, sq[3]};
    total_q   <= pair_q[0] + pair_q[1];
  end

  v4n_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  ({1'b0, total_q}),
    .root_o (root)
  );

  // Transaction tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= {valid_q[VALID_DEPTH-2:0], start & ~busy};
      done_q  <= valid_q[VALID_DEPTH-1];
    end
  end

  // Zero flag and length, delayed alongside the lanes.
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (in_i == '0);
    for (int i = 1; i < VALID_DEPTH; i++) begin
      zero_q[i] <= zero_q[i-1];
    end
    len_q[0] <= root;
    for (int i = 1; i < DIV_STAGES; i++) begin
      len_q[i] <= len_q[i-1];
    end
  end

  // Merge the lane results into the output register.
  always_ff @(posedge clk_i) begin
    if (zero_q[VALID_DEPTH-1]) begin
      res_q <= '{unit_x: '0, unit_y: '0, unit_z: '0, unit_w: '0,
                 length: '0, was_zero: 1'b1};
    end else begin
      res_q <= '{unit_x: unit[0], unit_y: unit[1], unit_z: unit[2],
                 unit_w: unit[3], length: len_q[DIV_STAGES-1], was_zero: 1'b0};
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

  // Every accepted transaction yields a result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  // An all-zero vector is flagged at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && in_i == '0) |-> ##LATENCY (done_o && res_o.was_zero))
    else $error("zero vector not flagged");

  // A nonzero vector always has a nonzero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.was_zero) |-> (res_o.length != '0))
    else $error("nonzero vector with zero length");

  // Flagged results carry zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.was_zero) |-> (res_o.length == '0 && res_o.unit_x == '0))
    else $error("zero vector result not cleared");

endmodule
